@@ design/ljpf_pkg.sv @@
// ----------------------------------------------------------------------------
// Lennard-Jones pair force package
// Shared widths, constants, status codes, item types and fixed-point helpers.
// ----------------------------------------------------------------------------
package ljpf_pkg;

  // Field and datapath widths.
  localparam int CFG_W         = 24;
  localparam int DATA_W        = 64;
  localparam int MAG_W         = 32;
  localparam int ENERGY_W      = 32;
  localparam int EPS_SHIFT     = 16;

  // Defaults for the top-level parameters.
  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;

  // Queue between the front and the back.
  localparam int QDEPTH = 8;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Latencies of the arithmetic units.
  localparam int DIV_STEPS = 64;
  localparam int DIV_LAT   = DIV_STEPS + 1;
  localparam int MUL_LAT   = 2;

  // Saturated Q32.32 magnitude and the scale limits.
  localparam logic [DATA_W-1:0] CLAMP       = '1;
  localparam logic [DATA_W-1:0] CLAMP_DIV4  = CLAMP / 64'd4;
  localparam logic [DATA_W-1:0] CLAMP_DIV48 = CLAMP / 64'd48;

  // Status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_CUTOFF = 2'd1;
  localparam logic [1:0] ST_SAT    = 2'd2;
  localparam logic [1:0] ST_ZERO   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SIGMA   = 2'd0;
  localparam logic [1:0] CFG_EPSILON = 2'd1;
  localparam logic [1:0] CFG_CUTOFF  = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [CFG_W-1:0] SIGMA_RST   = 24'd65536;
  localparam logic [CFG_W-1:0] EPSILON_RST = 24'd65536;
  localparam logic [CFG_W-1:0] CUTOFF_RST  = 24'd163840;

  // Classified item as it leaves the front.
  typedef struct packed {
    logic [DATA_W-1:0]           r2;
    logic [2:0][MAG_W-1:0]       mag;
    logic [2:0]                  neg;
    logic [1:0]                  cls;
  } entry_t;

  // Item as it travels down the back pipeline.
  typedef struct packed {
    entry_t                      ent;
    logic                        eneg;
    logic                        gneg;
    logic [ENERGY_W-1:0]         energy;
    logic                        esat;
  } item_t;

  // Multiply a Q32.32 magnitude by four, saturating.
  function automatic logic [DATA_W-1:0] scale4(input logic [DATA_W-1:0] a);
    logic [DATA_W-1:0] r;
    if (a == '0) r = '0;
    else if (a == CLAMP || a > CLAMP_DIV4) r = CLAMP;
    else r = a << 2;
    return r;
  endfunction

  // Multiply a Q32.32 magnitude by forty-eight, saturating.
  function automatic logic [DATA_W-1:0] scale48(input logic [DATA_W-1:0] a);
    logic [DATA_W-1:0] r;
    if (a == '0) r = '0;
    else if (a == CLAMP || a > CLAMP_DIV48) r = CLAMP;
    else r = (a << 5) + (a << 4);
    return r;
  endfunction

endpackage

@@ design/ljpf_front.sv @@
// ----------------------------------------------------------------------------
// Lennard-Jones front end
// Accepts displacement items, forms the squared distance and classifies each
// item as in range, beyond the cutoff or at zero distance.
// ----------------------------------------------------------------------------
module ljpf_front #(
  parameter int COORD_WIDTH = ljpf_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ljpf_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COORD_WIDTH-1:0]       disp_x,
  input  logic signed [COORD_WIDTH-1:0]       disp_y,
  input  logic signed [COORD_WIDTH-1:0]       disp_z,
  input  logic [ljpf_pkg::CFG_W-1:0]          cutoff,
  input  logic [ljpf_pkg::QCNT_W-1:0]         free,
  output logic                                push,
  output ljpf_pkg::entry_t                    push_data
);

  logic [2:0][COORD_WIDTH-1:0]          din;
  logic [2:0][ljpf_pkg::MAG_W-1:0]      mag_c;
  logic [2:0]                           neg_c;
  logic                                 accept;
  logic [ljpf_pkg::QCNT_W-1:0]          need;

  logic                                 s1_valid;
  logic [2:0][ljpf_pkg::MAG_W-1:0]      s1_mag;
  logic [2:0]                           s1_neg;
  logic                                 s2_valid;
  logic [2:0][ljpf_pkg::DATA_W-1:0]     s2_sq;
  logic [2:0][ljpf_pkg::MAG_W-1:0]      s2_mag;
  logic [2:0]                           s2_neg;
  logic [2*ljpf_pkg::CFG_W-1:0]         s2_cc;
  logic                                 s3_valid;
  logic [ljpf_pkg::DATA_W-1:0]          s3_r2;
  logic [2:0][ljpf_pkg::MAG_W-1:0]      s3_mag;
  logic [2:0]                           s3_neg;
  logic [2*ljpf_pkg::CFG_W-1:0]         s3_cc;

  logic [2*ljpf_pkg::DATA_W-1:0]        lhs;
  logic [2*ljpf_pkg::DATA_W-1:0]        rhs;

  // Hold off a new item unless every item in flight is sure of a queue slot.
  assign need = ljpf_pkg::QCNT_W'(s1_valid) + ljpf_pkg::QCNT_W'(s2_valid)
              + ljpf_pkg::QCNT_W'(s3_valid) + ljpf_pkg::QCNT_W'(1);
  assign busy   = need > free;
  assign accept = start && !busy;

  // Sign and magnitude of each component.
  assign din = {disp_z, disp_y, disp_x};
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_c[i] = din[i][COORD_WIDTH-1];
      mag_c[i] = ljpf_pkg::MAG_W'(din[i][COORD_WIDTH-1] ? (~din[i] + 1'b1) : din[i]);
    end
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
    end
  end

  // Magnitudes, squares, then the sum of squares.
  always_ff @(posedge clk) begin
    s1_mag <= mag_c;
    s1_neg <= neg_c;
    for (int i = 0; i < 3; i++) begin
      s2_sq[i] <= s1_mag[i] * s1_mag[i];
    end
    s2_mag <= s1_mag;
    s2_neg <= s1_neg;
    s2_cc  <= cutoff * cutoff;
    s3_r2  <= s2_sq[0] + s2_sq[1] + s2_sq[2];
    s3_mag <= s2_mag;
    s3_neg <= s2_neg;
    s3_cc  <= s2_cc;
  end

  // Compare r2 against cutoff squared at a common binary point.
  assign lhs = {s3_r2, 64'd0} >> 32;
  assign rhs = (2*ljpf_pkg::DATA_W)'(s3_cc) << (2*FRAC_BITS);

  always_comb begin
    push_data.r2  = s3_r2;
    push_data.mag = s3_mag;
    push_data.neg = s3_neg;
    if (lhs > rhs) push_data.cls = ljpf_pkg::ST_CUTOFF;
    else if (s3_r2 == '0) push_data.cls = ljpf_pkg::ST_ZERO;
    else push_data.cls = ljpf_pkg::ST_OK;
  end

  assign push = s3_valid;

endmodule

@@ design/ljpf_queue.sv @@
// ----------------------------------------------------------------------------
// Lennard-Jones item queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module ljpf_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  input  ljpf_pkg::entry_t             push_data,
  input  logic                         pop,
  output logic                         head_valid,
  output ljpf_pkg::entry_t             head_data,
  output logic [ljpf_pkg::QCNT_W-1:0]  free
);

  ljpf_pkg::entry_t                 mem [ljpf_pkg::QDEPTH];
  logic [ljpf_pkg::QPTR_W-1:0]      wr_ptr;
  logic [ljpf_pkg::QPTR_W-1:0]      rd_ptr;
  logic [ljpf_pkg::QCNT_W-1:0]      count;

  assign head_valid = count != '0;
  assign head_data  = mem[rd_ptr];
  assign free       = ljpf_pkg::QCNT_W'(ljpf_pkg::QDEPTH) - count;

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // Pointers and occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      count <= count + ljpf_pkg::QCNT_W'(push) - ljpf_pkg::QCNT_W'(pop);
    end
  end

  // The front never pushes into a full queue.
  assert property (@(posedge clk) disable iff (rst)
    push |-> count != ljpf_pkg::QCNT_W'(ljpf_pkg::QDEPTH))
    else $error("queue overflow");

  // The back never pops an empty queue.
  assert property (@(posedge clk) disable iff (rst)
    pop |-> count != '0)
    else $error("queue underflow");

endmodule

@@ design/ljpf_div.sv @@
// ----------------------------------------------------------------------------
// Lennard-Jones pipelined divider
// Computes (v << 2*FRAC_BITS) / d as a saturating Q32.32 quotient, one
// quotient bit per stage, accepting a new operand pair every cycle.
// ----------------------------------------------------------------------------
module ljpf_div #(
  parameter int FRAC_BITS = ljpf_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic [ljpf_pkg::DATA_W-1:0]   v,
  input  logic [ljpf_pkg::DATA_W-1:0]   d,
  output logic [ljpf_pkg::DATA_W-1:0]   quo
);

  localparam int S = ljpf_pkg::DIV_STEPS;

  logic [2*ljpf_pkg::DATA_W-1:0]  num;
  logic [ljpf_pkg::DATA_W-1:0]    rem [0:S];
  logic [ljpf_pkg::DATA_W-1:0]    lo  [0:S];
  logic [ljpf_pkg::DATA_W-1:0]    dd  [0:S];
  logic [ljpf_pkg::DATA_W-1:0]    qq  [0:S];
  logic [S:0]                     zf;
  logic [S:0]                     cf;

  assign num = (2*ljpf_pkg::DATA_W)'(v) << (2*FRAC_BITS);

  // Entry stage: special cases and the upper half of the numerator.
  always_ff @(posedge clk) begin
    zf[0]  <= v == '0;
    cf[0]  <= (v == ljpf_pkg::CLAMP) || (d == '0)
           || (num[2*ljpf_pkg::DATA_W-1:ljpf_pkg::DATA_W] >= d);
    rem[0] <= num[2*ljpf_pkg::DATA_W-1:ljpf_pkg::DATA_W];
    lo[0]  <= num[ljpf_pkg::DATA_W-1:0];
    dd[0]  <= d;
    qq[0]  <= '0;
  end

  // Restoring division, one bit per stage.
  for (genvar k = 0; k < S; k++) begin : g_step
    logic [ljpf_pkg::DATA_W:0] t;
    logic [ljpf_pkg::DATA_W:0] diff;
    logic                      ge;

    assign t    = {rem[k], lo[k][ljpf_pkg::DATA_W-1]};
    assign ge   = t >= {1'b0, dd[k]};
    assign diff = t - {1'b0, dd[k]};

    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? diff[ljpf_pkg::DATA_W-1:0] : t[ljpf_pkg::DATA_W-1:0];
      lo[k+1]  <= lo[k] << 1;
      dd[k+1]  <= dd[k];
      qq[k+1]  <= {qq[k][ljpf_pkg::DATA_W-2:0], ge};
      zf[k+1]  <= zf[k];
      cf[k+1]  <= cf[k];
    end
  end

  assign quo = zf[S] ? '0 : (cf[S] ? ljpf_pkg::CLAMP : qq[S]);

endmodule

@@ design/ljpf_qmul.sv @@
// ----------------------------------------------------------------------------
// Lennard-Jones fixed-point multiplier
// Two-stage saturating Q32.32 product built from four 32x32 partial products.
// ----------------------------------------------------------------------------
module ljpf_qmul (
  input  logic                          clk,
  input  logic [ljpf_pkg::DATA_W-1:0]   a,
  input  logic [ljpf_pkg::DATA_W-1:0]   b,
  output logic [ljpf_pkg::DATA_W-1:0]   p
);

  logic [ljpf_pkg::DATA_W-1:0]    ll_c, lh_c, hl_c, hh_c;
  logic [ljpf_pkg::DATA_W-1:0]    ll, lh, hl, hh;
  logic                           zero_r;
  logic                           clamp_r;
  logic [2*ljpf_pkg::DATA_W-1:0]  sum;

  assign ll_c = a[31:0]  * b[31:0];
  assign lh_c = a[31:0]  * b[63:32];
  assign hl_c = a[63:32] * b[31:0];
  assign hh_c = a[63:32] * b[63:32];

  // Partial products and operand flags.
  always_ff @(posedge clk) begin
    ll      <= ll_c;
    lh      <= lh_c;
    hl      <= hl_c;
    hh      <= hh_c;
    zero_r  <= (a == '0) || (b == '0);
    clamp_r <= (a == ljpf_pkg::CLAMP) || (b == ljpf_pkg::CLAMP);
  end

  assign sum = {64'd0, ll} + {32'd0, lh, 32'd0} + {32'd0, hl, 32'd0} + {hh, 64'd0};

  // Recombine, rescale and saturate.
  always_ff @(posedge clk) begin
    if (zero_r) p <= '0;
    else if (clamp_r || sum[127:96] != '0) p <= ljpf_pkg::CLAMP;
    else p <= sum[95:32];
  end

endmodule

@@ design/ljpf_back.sv @@
// ----------------------------------------------------------------------------
// Lennard-Jones back end
// Pipeline that turns a classified item into energy, force and status.
// ----------------------------------------------------------------------------
module ljpf_back #(
  parameter int COORD_WIDTH = ljpf_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ljpf_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          head_valid,
  input  ljpf_pkg::entry_t              head_data,
  output logic                          pop,
  input  logic [ljpf_pkg::CFG_W-1:0]    sigma,
  input  logic [ljpf_pkg::CFG_W-1:0]    epsilon,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] force_x,
  output logic signed [COORD_WIDTH-1:0] force_y,
  output logic signed [COORD_WIDTH-1:0] force_z,
  output logic signed [COORD_WIDTH-1:0] pair_energy,
  output logic [1:0]                    status
);

  // Where each intermediate value lines up with the item pipeline.
  localparam int I_Q   = ljpf_pkg::DIV_LAT;
  localparam int I_Q2  = I_Q + ljpf_pkg::MUL_LAT;
  localparam int I_S6  = I_Q2 + ljpf_pkg::MUL_LAT;
  localparam int I_S12 = I_S6 + ljpf_pkg::MUL_LAT;
  localparam int I_BR  = I_S12 + 1;
  localparam int I_EG  = I_BR + ljpf_pkg::MUL_LAT;
  localparam int I_SC  = I_EG + 1;
  localparam int I_CF  = I_SC + ljpf_pkg::DIV_LAT;
  localparam int I_FM  = I_CF + ljpf_pkg::MUL_LAT;
  localparam int ESH   = 32 - FRAC_BITS;
  localparam logic [ljpf_pkg::DATA_W-1:0] HALF = 64'd1 << (COORD_WIDTH - 1);

  localparam int DW = ljpf_pkg::DATA_W;

  ljpf_pkg::item_t       pl [0:I_FM];
  logic [I_FM:0]         vld;

  logic [2*ljpf_pkg::CFG_W-1:0] sig2_c;
  logic [DW-1:0]         sig2_r;
  logic [DW-1:0]         eps32;
  logic [DW-1:0]         q, q2, s6, s12, e1, g1, coef;
  logic [DW-1:0]         qd0, qd1, s6d0, s6d1;
  logic [DW-1:0]         emag_c, gmag_c, emag_r, gmag_r, g48_r;
  logic                  eneg_c, gneg_c;
  logic [DW-1:0]         e4, es;
  logic [COORD_WIDTH:0]  eenc;
  logic [2:0][DW-1:0]    fm;
  logic [2:0][COORD_WIDTH:0] fenc;

  // Saturate a sign and magnitude into the output format; the top bit flags a clamp.
  function automatic logic [COORD_WIDTH:0] enc(input logic neg, input logic [DW-1:0] mag);
    logic [DW-1:0]          lim;
    logic [DW-1:0]          m;
    logic                   s;
    logic [COORD_WIDTH-1:0] val;
    lim = neg ? HALF : HALF - 1'b1;
    s   = mag > lim;
    m   = s ? lim : mag;
    val = neg ? (COORD_WIDTH'(0) - m[COORD_WIDTH-1:0]) : m[COORD_WIDTH-1:0];
    return {s, val};
  endfunction

  // The back never stalls, so it takes every queued item at once.
  assign pop   = head_valid;
  assign eps32 = DW'(epsilon) << ljpf_pkg::EPS_SHIFT;

  // Item valid line.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[I_FM-1:0], head_valid};
    end
  end

  // Item payload line, with fields filled in as they are computed.
  always_ff @(posedge clk) begin
    pl[0] <= '{ent: head_data, eneg: 1'b0, gneg: 1'b0, energy: '0, esat: 1'b0};
    for (int k = 1; k <= I_FM; k++) begin
      if (k == I_BR) begin
        pl[k] <= '{ent: pl[k-1].ent, eneg: eneg_c, gneg: gneg_c,
                   energy: pl[k-1].energy, esat: pl[k-1].esat};
      end else if (k == I_SC) begin
        pl[k] <= '{ent: pl[k-1].ent, eneg: pl[k-1].eneg, gneg: pl[k-1].gneg,
                   energy: ljpf_pkg::ENERGY_W'(eenc[COORD_WIDTH-1:0]),
                   esat: eenc[COORD_WIDTH]};
      end else begin
        pl[k] <= pl[k-1];
      end
    end
  end

  // The user keeps sigma squared stable while items are in flight; not enforced.
  assign sig2_c = sigma * sigma;

  always_ff @(posedge clk) begin
    sig2_r <= DW'(sig2_c);
  end

  // q = sigma^2 / r2.
  ljpf_div #(.FRAC_BITS(FRAC_BITS)) u_div_q (
    .clk(clk), .v(sig2_r), .d(pl[0].ent.r2), .quo(q)
  );

  // s6 = q^3 and s12 = s6^2.
  ljpf_qmul u_mul_q2 (.clk(clk), .a(q), .b(q), .p(q2));
  ljpf_qmul u_mul_s6 (.clk(clk), .a(q2), .b(qd1), .p(s6));
  ljpf_qmul u_mul_s12 (.clk(clk), .a(s6), .b(s6), .p(s12));

  always_ff @(posedge clk) begin
    qd0  <= q;
    qd1  <= qd0;
    s6d0 <= s6;
    s6d1 <= s6d0;
  end

  // Energy bracket s12 - s6 and force bracket s12 - s6/2.
  always_comb begin
    if (s12 == ljpf_pkg::CLAMP) begin
      eneg_c = 1'b0;
      emag_c = ljpf_pkg::CLAMP;
      gneg_c = 1'b0;
      gmag_c = ljpf_pkg::CLAMP;
    end else begin
      eneg_c = s12 < s6d1;
      emag_c = eneg_c ? s6d1 - s12 : s12 - s6d1;
      gneg_c = s12 < (s6d1 >> 1);
      gmag_c = gneg_c ? (s6d1 >> 1) - s12 : s12 - (s6d1 >> 1);
    end
  end

  always_ff @(posedge clk) begin
    emag_r <= emag_c;
    gmag_r <= gmag_c;
  end

  // Scale both brackets by epsilon.
  ljpf_qmul u_mul_e (.clk(clk), .a(emag_r), .b(eps32), .p(e1));
  ljpf_qmul u_mul_g (.clk(clk), .a(gmag_r), .b(eps32), .p(g1));

  // Energy: times four, back to the output binary point, saturated.
  assign e4   = ljpf_pkg::scale4(e1);
  assign es   = (e4 == ljpf_pkg::CLAMP) ? e4 : e4 >> ESH;
  assign eenc = enc(pl[I_EG].eneg && es != '0, es);

  always_ff @(posedge clk) begin
    g48_r <= ljpf_pkg::scale48(g1);
  end

  // Force coefficient 48*eps*bracket / r2.
  ljpf_div #(.FRAC_BITS(FRAC_BITS)) u_div_c (
    .clk(clk), .v(g48_r), .d(pl[I_SC].ent.r2), .quo(coef)
  );

  // Force components coefficient * |d_i|.
  for (genvar i = 0; i < 3; i++) begin : g_force
    ljpf_qmul u_mul_f (
      .clk(clk), .a(coef), .b(DW'(pl[I_CF].ent.mag[i])), .p(fm[i])
    );
    assign fenc[i] = enc((pl[I_FM].gneg == pl[I_FM].ent.neg[i]) && fm[i] != '0, fm[i]);
  end

  // Result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= vld[I_FM];
    end
  end

  // Result register; out-of-range and zero-distance items give zeros.
  always_ff @(posedge clk) begin
    if (pl[I_FM].ent.cls == ljpf_pkg::ST_OK) begin
      force_x     <= fenc[0][COORD_WIDTH-1:0];
      force_y     <= fenc[1][COORD_WIDTH-1:0];
      force_z     <= fenc[2][COORD_WIDTH-1:0];
      pair_energy <= pl[I_FM].energy[COORD_WIDTH-1:0];
      if (pl[I_FM].esat || fenc[0][COORD_WIDTH] || fenc[1][COORD_WIDTH]
          || fenc[2][COORD_WIDTH]) begin
        status <= ljpf_pkg::ST_SAT;
      end else begin
        status <= ljpf_pkg::ST_OK;
      end
    end else begin
      force_x     <= '0;
      force_y     <= '0;
      force_z     <= '0;
      pair_energy <= '0;
      status      <= pl[I_FM].ent.cls;
    end
  end

  // A pair beyond the cutoff carries no force and no energy.
  assert property (@(posedge clk) disable iff (rst)
    done && status == ljpf_pkg::ST_CUTOFF |->
      force_x == '0 && force_y == '0 && force_z == '0 && pair_energy == '0)
    else $error("nonzero result beyond cutoff");

  // The done strobe is registered from the last stage of the item valid line.
  assert property (@(posedge clk) disable iff (rst)
    vld[I_FM] |=> done)
    else $error("result strobe lost");

endmodule

@@ design/lennard_jones_pair_force_top.sv @@
// ----------------------------------------------------------------------------
// Lennard-Jones 12-6 pair force engine
// Energy and force of one displacement vector per item, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Drive disp_x/y/z with start high; the item is taken at a rising edge where
//   start is high and busy is low. One item can be taken every cycle while busy
//   stays low. Each result appears on force_x/y/z, pair_energy and status for
//   exactly one cycle, marked by done. Results leave in the order their items
//   came in. The receiver cannot stall; a result is taken at the edge that ends
//   its done cycle. Results pass through the two 64-step pipelined dividers
//   (sigma^2 / r2 and the force coefficient / r2), one quotient bit per stage,
//   plus the two-stage multipliers, the front classifier and the item queue.
//   Status: 0 ok, 1 beyond cutoff, 2 saturated, 3 zero distance.
//   Configuration (sigma, epsilon, cutoff) is written over cfg_valid/cfg_ready
//   with cfg_index and cfg_data; the user must do so only while no item is in
//   flight, as the block does not enforce it. Reset empties the pipeline and
//   restores sigma 1.0, epsilon 1.0, cutoff 2.5.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force_top #(
  parameter int COORD_WIDTH = ljpf_pkg::COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = ljpf_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] disp_x,
  input  logic signed [COORD_WIDTH-1:0] disp_y,
  input  logic signed [COORD_WIDTH-1:0] disp_z,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [ljpf_pkg::CFG_W-1:0]    cfg_data,
  output logic                          done,
  output logic signed [COORD_WIDTH-1:0] force_x,
  output logic signed [COORD_WIDTH-1:0] force_y,
  output logic signed [COORD_WIDTH-1:0] force_z,
  output logic signed [COORD_WIDTH-1:0] pair_energy,
  output logic [1:0]                    status
);

  logic [ljpf_pkg::CFG_W-1:0]   sigma;
  logic [ljpf_pkg::CFG_W-1:0]   epsilon;
  logic [ljpf_pkg::CFG_W-1:0]   cutoff;

  logic                         push;
  ljpf_pkg::entry_t             push_data;
  logic                         pop;
  logic                         head_valid;
  ljpf_pkg::entry_t             head_data;
  logic [ljpf_pkg::QCNT_W-1:0]  free;

  // Configuration registers; unknown indexes are ignored.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sigma   <= ljpf_pkg::SIGMA_RST;
      epsilon <= ljpf_pkg::EPSILON_RST;
      cutoff  <= ljpf_pkg::CUTOFF_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ljpf_pkg::CFG_SIGMA:   sigma   <= cfg_data;
        ljpf_pkg::CFG_EPSILON: epsilon <= cfg_data;
        ljpf_pkg::CFG_CUTOFF:  cutoff  <= cfg_data;
        default: ;
      endcase
    end
  end

  ljpf_front #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .disp_x(disp_x), .disp_y(disp_y), .disp_z(disp_z),
    .cutoff(cutoff), .free(free), .push(push), .push_data(push_data)
  );

  ljpf_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .pop(pop),
    .head_valid(head_valid), .head_data(head_data), .free(free)
  );

  ljpf_back #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk(clk), .rst(rst), .head_valid(head_valid), .head_data(head_data), .pop(pop),
    .sigma(sigma), .epsilon(epsilon), .done(done),
    .force_x(force_x), .force_y(force_y), .force_z(force_z),
    .pair_energy(pair_energy), .status(status)
  );

endmodule

@@ tb/lennard_jones_pair_force_top_test.sv @@
// ----------------------------------------------------------------------------
// Lennard-Jones pair force engine testbench
// Drives displacement items through the engine under several sigma, epsilon
// and cutoff settings. Each item's force, energy and status are predicted in
// fixed point and checked against the engine's results in order.
// ----------------------------------------------------------------------------
module lennard_jones_pair_force_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int W = 32;
  localparam int FB = 16;
  localparam int LATENCY = 147;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [63:0] SAT_MAG = '1;
  // Register index that names no register.
  localparam logic [1:0] CFG_NONE = 2'd3;

  typedef struct {
    logic [W-1:0] fx;
    logic [W-1:0] fy;
    logic [W-1:0] fz;
    logic [W-1:0] energy;
    logic [1:0]   st;
  } pair_result_t;

  logic clk, rst, start, busy, cfg_valid, cfg_ready, done;
  logic signed [W-1:0] disp_x, disp_y, disp_z;
  logic signed [W-1:0] force_x, force_y, force_z, pair_energy;
  logic [1:0] cfg_index, status;
  logic [ljpf_pkg::CFG_W-1:0] cfg_data;

  logic [63:0] sigma_q, epsilon_q, cutoff_q;
  int fail_count;
  int cycle_count;

  lennard_jones_pair_force_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .disp_x(disp_x), .disp_y(disp_y), .disp_z(disp_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .force_x(force_x), .force_y(force_y),
    .force_z(force_z), .pair_energy(pair_energy), .status(status)
  );

  // Print one mismatch line and count it.
  task automatic report_mismatch(input string what, input logic [W-1:0] got,
                                 input logic [W-1:0] want);
    $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  // Saturating Q32.32 quotient (v << 32) / d.
  function automatic logic [63:0] fx_div(input logic [63:0] v, input logic [63:0] d);
    logic [127:0] n;
    if (v == 0) return 0;
    if (v == SAT_MAG || d == 0) return SAT_MAG;
    n = {64'd0, v} << (2 * FB);
    if (n[127:64] >= d) return SAT_MAG;
    return 64'(n / {64'd0, d});
  endfunction

  // Saturating Q32.32 product.
  function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    if (a == 0 || b == 0) return 0;
    if (a == SAT_MAG || b == SAT_MAG) return SAT_MAG;
    p = {64'd0, a} * {64'd0, b};
    if (p[127:96] != 0) return SAT_MAG;
    return p[95:32];
  endfunction

  // Saturating multiply by a small integer.
  function automatic logic [63:0] fx_scale(input logic [63:0] a, input logic [63:0] k);
    if (a == 0) return 0;
    if (a == SAT_MAG || a > SAT_MAG / k) return SAT_MAG;
    return a * k;
  endfunction

  // Signed output with saturation to the field width.
  function automatic logic [W-1:0] to_field(input logic neg, input logic [63:0] mag,
                                            inout logic sat);
    logic [63:0] lim;
    lim = neg ? (64'd1 << (W - 1)) : (64'd1 << (W - 1)) - 1;
    if (mag > lim) begin
      mag = lim;
      sat = 1'b1;
    end
    return neg ? W'(-mag) : W'(mag);
  endfunction

  // Compute the forces, energy and status expected for one displacement.
  function automatic pair_result_t lj_predict(input logic [W-1:0] d [3]);
    pair_result_t r;
    logic [63:0] mag [3];
    logic neg [3];
    logic [63:0] r2, q, s6, s12, eps32, emag, gmag, coef, fm;
    logic [127:0] p;
    logic eneg, gneg, sat;
    logic [W-1:0] f [3];
    r2 = 0;
    sat = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = d[i][W-1];
      mag[i] = neg[i] ? 64'(W'(-d[i])) : 64'(d[i]);
      r2 += mag[i] * mag[i];
    end
    r = '{default: '0};
    if ({r2, 32'd0} > ({32'd0, cutoff_q * cutoff_q} << (2 * FB))) begin
      r.st = ljpf_pkg::ST_CUTOFF;
      return r;
    end
    if (r2 == 0) begin
      r.st = ljpf_pkg::ST_ZERO;
      return r;
    end
    q = fx_div(sigma_q * sigma_q, r2);
    s6 = fx_mul(fx_mul(q, q), q);
    s12 = fx_mul(s6, s6);
    eps32 = epsilon_q << 16;
    if (s12 == SAT_MAG) begin
      eneg = 0; emag = SAT_MAG;
    end else if (s12 >= s6) begin
      eneg = 0; emag = s12 - s6;
    end else begin
      eneg = 1; emag = s6 - s12;
    end
    emag = fx_scale(fx_mul(emag, eps32), 4);
    if (emag != SAT_MAG) emag >>= (32 - FB);
    r.energy = to_field(eneg && emag != 0, emag, sat);
    if (s12 == SAT_MAG) begin
      gneg = 0; gmag = SAT_MAG;
    end else if (s12 >= (s6 >> 1)) begin
      gneg = 0; gmag = s12 - (s6 >> 1);
    end else begin
      gneg = 1; gmag = (s6 >> 1) - s12;
    end
    coef = fx_div(fx_scale(fx_mul(gmag, eps32), 48), r2);
    for (int i = 0; i < 3; i++) begin
      if (coef == 0 || mag[i] == 0) fm = 0;
      else if (coef == SAT_MAG) fm = SAT_MAG;
      else begin
        p = {64'd0, coef} * {64'd0, mag[i]};
        fm = (p[127:96] != 0) ? SAT_MAG : p[95:32];
      end
      f[i] = to_field(gneg == neg[i] && fm != 0, fm, sat);
    end
    r.fx = f[0];
    r.fy = f[1];
    r.fz = f[2];
    r.st = sat ? ljpf_pkg::ST_SAT : ljpf_pkg::ST_OK;
    return r;
  endfunction

  // Holds the predicted results of accepted items, oldest first.
  class lj_scoreboard;
    pair_result_t pending[$];

    function void note_item(input logic [W-1:0] d [3]);
      pending.push_back(lj_predict(d));
    endfunction

    task check_result(input pair_result_t got);
      pair_result_t want;
      if (pending.size() == 0) begin
        $display("[%0t] result with no item outstanding", $realtime);
        fail_count++;
        return;
      end
      want = pending.pop_front();
      if (got.fx !== want.fx) report_mismatch("force_x", got.fx, want.fx);
      if (got.fy !== want.fy) report_mismatch("force_y", got.fy, want.fy);
      if (got.fz !== want.fz) report_mismatch("force_z", got.fz, want.fz);
      if (got.energy !== want.energy) report_mismatch("pair_energy", got.energy, want.energy);
      if (got.st !== want.st) report_mismatch("status", W'(got.st), W'(want.st));
    endtask
  endclass

  lj_scoreboard results_sb = new();

  // Clock.
  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // Result monitor and cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst && done)
      results_sb.check_result('{force_x, force_y, force_z, pair_energy, status});
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Write one configuration register and mirror it; valid drops for a cycle after.
  task automatic write_reg(input logic [1:0] idx, input logic [ljpf_pkg::CFG_W-1:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    case (idx)
      ljpf_pkg::CFG_SIGMA: sigma_q = val;
      ljpf_pkg::CFG_EPSILON: epsilon_q = val;
      ljpf_pkg::CFG_CUTOFF: cutoff_q = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Present one item and hold it until accepted; start stays high if more follow,
  // otherwise it drops.
  task automatic send_pair(input logic [W-1:0] x, input logic [W-1:0] y,
                           input logic [W-1:0] z, input bit keep);
    logic [W-1:0] d [3];
    d = '{x, y, z};
    start <= 1;
    disp_x <= x;
    disp_y <= y;
    disp_z <= z;
    @(posedge clk);
    while (busy) @(posedge clk);
    results_sb.note_item(d);
    if (!keep) begin
      start <= 0;
      @(posedge clk);
    end
  endtask

  // Let the pipeline empty before touching configuration.
  task automatic drain;
    while (results_sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // One random coordinate: mostly near the interaction range, sometimes wild.
  function automatic logic [W-1:0] rand_coord();
    case ($urandom_range(9))
      0: return $urandom();
      1: return W'($signed($urandom_range(255)) - 128);
      2: return $urandom_range(1) ? 32'h8000_0000 : 32'h7fff_ffff;
      default: return W'($signed($urandom_range(6 << FB)) - (3 << FB));
    endcase
  endfunction

  // Bursts of random items with random gaps.
  task automatic random_burst_phase(input int n);
    int burst;
    while (n > 0) begin
      burst = $urandom_range(3) == 0 ? 1 : $urandom_range(20, 1);
      for (int i = 0; i < burst && n > 0; i++, n--)
        send_pair(rand_coord(), rand_coord(), rand_coord(), i < burst - 1 && n > 1);
      if ($urandom_range(2) != 0) repeat ($urandom_range(6)) @(posedge clk);
    end
  endtask

  initial begin
    logic [ljpf_pkg::CFG_W-1:0] sig_list [5], eps_list [5], cut_list [5];
    sig_list = '{24'h010000, 24'h000000, 24'hffffff, 24'h00c000, 24'h018000};
    eps_list = '{24'h010000, 24'h004000, 24'h000000, 24'hffffff, 24'h000001};
    cut_list = '{24'h028000, 24'hffffff, 24'h030000, 24'h000000, 24'h020000};
    fail_count = 0;
    cycle_count = 0;
    rst = 1;
    start = 0;
    cfg_valid = 0;
    cfg_index = ljpf_pkg::CFG_SIGMA;
    cfg_data = 0;
    disp_x = 0;
    disp_y = 0;
    disp_z = 0;
    sigma_q = ljpf_pkg::SIGMA_RST;
    epsilon_q = ljpf_pkg::EPSILON_RST;
    cutoff_q = ljpf_pkg::CUTOFF_RST;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Directed items under reset values.
    send_pair(0, 0, 0, 1);
    send_pair(32'h0001_0000, 0, 0, 1);
    send_pair(32'hffff_0000, 0, 0, 1);
    send_pair(32'h0001_1f5c, 0, 0, 1);
    send_pair(32'h0000_8000, 32'h0000_8000, 0, 1);
    send_pair(32'h0000_0001, 0, 0, 1);
    send_pair(32'h0000_2000, 32'hffff_e000, 32'h0000_1000, 1);
    send_pair(32'h0002_8000, 0, 0, 1);
    send_pair(32'h0002_8001, 0, 0, 1);
    send_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 1);
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1);
    send_pair(32'h0000_c000, 32'hffff_4000, 32'h0000_c000, 1);
    send_pair(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1);
    send_pair(32'h0001_8000, 32'h0000_8000, 32'hfffe_0000, 0);

    // Hold off until everything has come back, then run random phases.
    drain();
    random_burst_phase(80);
    for (int ph = 0; ph < 5; ph++) begin
      drain();
      write_reg(ljpf_pkg::CFG_SIGMA, sig_list[ph]);
      write_reg(ljpf_pkg::CFG_EPSILON, eps_list[ph]);
      write_reg(ljpf_pkg::CFG_CUTOFF, cut_list[ph]);
      // An out-of-range index is ignored.
      if (ph == 2) write_reg(CFG_NONE, 24'h123456);
      send_pair(32'h0001_0000, 32'h0000_4000, 0, 0);
      random_burst_phase(100);
    end

    drain();
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
